// ===== rtl/vtfp_pkg.sv =====
package vtfp_pkg;

  localparam logic [7:0] FLAG_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_CODE_ESC  = 8'h01;
  localparam logic [7:0] ESC_CODE_FLAG = 8'h02;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic REG_ESCAPE_ENABLE = 1'b0;
  localparam logic REG_CHECK_ENABLE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_CHECK_ERR = 3'd2,
    ST_BAD_END   = 3'd3,
    ST_BAD_ESC   = 3'd4
  } status_t;

  typedef struct packed {
    logic escape_enable;
    logic check_enable;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [15:0] message_id;
    logic [9:0]  body_length;
    logic [2:0]  encrypt_mode;
    logic        subpackage_flag;
    logic        version_flag;
    logic [7:0]  protocol_version;
    logic [15:0] phone_high;
    logic [63:0] phone_low;
    logic [15:0] flow_id;
    status_t     status;
  } result_t;

endpackage

// ===== rtl/vtfp_if.sv =====
interface vtfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface vtfp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  body_byte;
  logic [15:0] message_id;
  logic [9:0]  body_length;
  logic [2:0]  encrypt_mode;
  logic        subpackage_flag;
  logic        version_flag;
  logic [7:0]  protocol_version;
  logic [15:0] phone_high;
  logic [63:0] phone_low;
  logic [15:0] flow_id;
  logic [2:0]  status;

  modport source (
    output valid, output kind, output body_byte, output message_id, output body_length,
    output encrypt_mode, output subpackage_flag, output version_flag,
    output protocol_version, output phone_high, output phone_low, output flow_id,
    output status, input ready
  );
  modport sink (
    input valid, input kind, input body_byte, input message_id, input body_length,
    input encrypt_mode, input subpackage_flag, input version_flag,
    input protocol_version, input phone_high, input phone_low, input flow_id,
    input status, output ready
  );
endinterface

// ===== rtl/vtfp_cfg.sv =====
module vtfp_cfg
  import vtfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_enable <= 1'b1;
      cfg.check_enable  <= 1'b1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ESCAPE_ENABLE: cfg.escape_enable <= pwdata[0];
        REG_CHECK_ENABLE:  cfg.check_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ESCAPE_ENABLE: prdata = {31'b0, cfg.escape_enable};
      REG_CHECK_ENABLE:  prdata = {31'b0, cfg.check_enable};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/vtfp_parse.sv =====
module vtfp_parse
  import vtfp_pkg::*;
#(
  parameter int unsigned PHONE_BYTES = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_take,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  localparam logic [9:0] HDR_LEN   = 10'(7 + PHONE_BYTES);
  localparam logic [9:0] PHONE_END = 10'(5 + PHONE_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_BODY, PH_CHECK, PH_END
  } phase_t;

  phase_t      phase, phase_next;
  logic [9:0]  cnt, cnt_next;
  logic [7:0]  xr, xr_next;
  logic        esc_pend, esc_pend_next;
  logic [15:0] id_reg, id_next;
  logic [15:0] props, props_next;
  logic [7:0]  ver, ver_next;
  logic [15:0] ph_hi, ph_hi_next;
  logic [63:0] ph_lo, ph_lo_next;
  logic [15:0] serial, serial_next;
  logic        res_valid;
  result_t     res;
  result_t     hdr_res;
  logic [7:0]  v;
  logic        have_v;
  logic [9:0]  cnt_inc;

  assign in_take = in_valid && (!out_valid || out_ready);
  assign cnt_inc = cnt + 10'd1;

  always_comb begin
    hdr_res                  = '0;
    hdr_res.kind             = KIND_SUMMARY;
    hdr_res.message_id       = id_reg;
    hdr_res.body_length      = props[9:0];
    hdr_res.encrypt_mode     = props[12:10];
    hdr_res.subpackage_flag  = props[13];
    hdr_res.version_flag     = props[14];
    hdr_res.protocol_version = ver;
    hdr_res.phone_high       = ph_hi;
    hdr_res.phone_low        = ph_lo;
    hdr_res.flow_id          = serial;
    hdr_res.status           = ST_OK;
  end

  always_comb begin
    phase_next    = phase;
    cnt_next      = cnt;
    xr_next       = xr;
    esc_pend_next = esc_pend;
    id_next       = id_reg;
    props_next    = props;
    ver_next      = ver;
    ph_hi_next    = ph_hi;
    ph_lo_next    = ph_lo;
    serial_next   = serial;
    res_valid     = 1'b0;
    res           = hdr_res;
    v             = in_byte;
    have_v        = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (in_byte == FLAG_BYTE) begin
          phase_next    = PH_HEADER;
          cnt_next      = '0;
          xr_next       = '0;
          esc_pend_next = 1'b0;
          id_next       = '0;
          props_next    = '0;
          ver_next      = '0;
          ph_hi_next    = '0;
          ph_lo_next    = '0;
          serial_next   = '0;
        end else begin
          res_valid  = 1'b1;
          res        = '0;
          res.kind   = KIND_SUMMARY;
          res.status = ST_BAD_START;
        end
      end
      PH_END: begin
        res_valid  = 1'b1;
        phase_next = PH_IDLE;
        if (in_byte != FLAG_BYTE) begin
          res.status = ST_BAD_END;
        end else if (cfg.check_enable && xr != 8'h00) begin
          res.status = ST_CHECK_ERR;
        end else begin
          res.status = ST_OK;
        end
      end
      default: begin
        if (cfg.escape_enable) begin
          if (esc_pend) begin
            esc_pend_next = 1'b0;
            if (in_byte == ESC_CODE_ESC) begin
              v      = ESC_BYTE;
              have_v = 1'b1;
            end else if (in_byte == ESC_CODE_FLAG) begin
              v      = FLAG_BYTE;
              have_v = 1'b1;
            end else begin
              res_valid  = 1'b1;
              res.status = ST_BAD_ESC;
              phase_next = PH_IDLE;
            end
          end else if (in_byte == ESC_BYTE) begin
            esc_pend_next = 1'b1;
          end else if (in_byte == FLAG_BYTE) begin
            res_valid     = 1'b1;
            res.status    = ST_BAD_END;
            phase_next    = PH_HEADER;
            cnt_next      = '0;
            xr_next       = '0;
            esc_pend_next = 1'b0;
            id_next       = '0;
            props_next    = '0;
            ver_next      = '0;
            ph_hi_next    = '0;
            ph_lo_next    = '0;
            serial_next   = '0;
          end else begin
            have_v = 1'b1;
          end
        end else begin
          esc_pend_next = 1'b0;
          have_v        = 1'b1;
        end

        if (have_v) begin
          xr_next = xr ^ v;
          case (phase)
            PH_HEADER: begin
              if (cnt == 10'd0) begin
                id_next[15:8] = v;
              end else if (cnt == 10'd1) begin
                id_next[7:0] = v;
              end else if (cnt == 10'd2) begin
                props_next[15:8] = v;
              end else if (cnt == 10'd3) begin
                props_next[7:0] = v;
              end else if (cnt == 10'd4) begin
                ver_next = v;
              end else if (cnt < PHONE_END) begin
                ph_hi_next = {ph_hi[7:0], ph_lo[63:56]};
                ph_lo_next = {ph_lo[55:0], v};
              end else if (cnt == PHONE_END) begin
                serial_next[15:8] = v;
              end else begin
                serial_next[7:0] = v;
              end
              if (cnt_inc >= HDR_LEN) begin
                cnt_next   = '0;
                phase_next = (props_next[9:0] != 10'd0) ? PH_BODY : PH_CHECK;
              end else begin
                cnt_next = cnt_inc;
              end
            end
            PH_BODY: begin
              cnt_next = cnt_inc;
              if (cnt_inc >= props[9:0]) begin
                phase_next = PH_CHECK;
              end
              res_valid     = 1'b1;
              res.kind      = KIND_BODY;
              res.body_byte = v;
              res.status    = ST_OK;
            end
            default: begin
              phase_next = PH_END;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cnt       <= '0;
      xr        <= '0;
      esc_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        phase    <= phase_next;
        cnt      <= cnt_next;
        xr       <= xr_next;
        esc_pend <= esc_pend_next;
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      id_reg <= id_next;
      props  <= props_next;
      ver    <= ver_next;
      ph_hi  <= ph_hi_next;
      ph_lo  <= ph_lo_next;
      serial <= serial_next;
      if (res_valid) begin
        out_res <= res;
      end
    end
  end

  a_idle_no_esc: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !esc_pend)
    else $error("escape pending while idle");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> cnt < props[9:0])
    else $error("body count past body length");

  a_body_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_BODY |-> out_res.status == ST_OK)
    else $error("body word with nonzero status");

  a_bad_start_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == ST_BAD_START |->
      out_res.message_id == 16'd0 && out_res.phone_low == 64'd0 && out_res.flow_id == 16'd0)
    else $error("bad start word carries header fields");

endmodule

// ===== rtl/vehicle_terminal_frame_parser.sv =====
// Channel  Dir  Handshake     Payload
// rx       in   valid/ready   rx_byte[7:0]
// res      out  valid/ready   kind, body_byte, header fields, status[2:0]
// apb      in   psel/penable  paddr[2:0], pwdata[31:0] (escape_enable @0, check_enable @4)
//
// One rx byte per cycle sustained while res is not stalled; a byte reaches res through the
// input register and the result register.
// rst is synchronous, active high: parser idle, both enables set, no word held.
// A stalled res holds its word; rx keeps flowing until the input register fills.
module vehicle_terminal_frame_parser
  import vtfp_pkg::*;
#(
  parameter int unsigned PHONE_BYTES = 10
) (
  input  logic          clk,
  input  logic          rst,
  vtfp_byte_if.sink     rx,
  vtfp_result_if.source res,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_take;
  result_t    out_res;

  vtfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign rx.ready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  vtfp_parse #(
    .PHONE_BYTES (PHONE_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_take   (in_take),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.kind             = out_res.kind;
  assign res.body_byte        = out_res.body_byte;
  assign res.message_id       = out_res.message_id;
  assign res.body_length      = out_res.body_length;
  assign res.encrypt_mode     = out_res.encrypt_mode;
  assign res.subpackage_flag  = out_res.subpackage_flag;
  assign res.version_flag     = out_res.version_flag;
  assign res.protocol_version = out_res.protocol_version;
  assign res.phone_high       = out_res.phone_high;
  assign res.phone_low        = out_res.phone_low;
  assign res.flow_id          = out_res.flow_id;
  assign res.status           = out_res.status;

endmodule
